// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/skvt_pkg.sv -----
// shared types and constants for the sorted key-value table
// no dependencies
package skvt_pkg;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    FUNC_SET = 2'd0, FUNC_LOOKUP = 2'd1, FUNC_READ = 2'd2, FUNC_DELETE = 2'd3
  } func_e;

  typedef enum logic {CFG_ORDERED = 1'b0, CFG_SCAN = 1'b1} cfg_idx_e;

  typedef struct packed {
    logic [1:0] func;
    logic signed [31:0] key;
    logic [31:0] value;
    logic [7:0] index;
  } req_t;

  typedef struct packed {
    logic found;
    logic [7:0] position;
    logic signed [31:0] out_key;
    logic [31:0] out_value;
    logic [8:0] entry_count;
    logic cache_hit;
    logic table_full;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_RD_MID, OP_BS_CMP, OP_RD_PTR, OP_LIN_CMP, OP_INS_PREP,
    OP_RD_PREV, OP_WR_UP, OP_WRITE, OP_RD_LOC, OP_CAPTURE, OP_RD_NEXT, OP_WR_DN,
    OP_RESULT
  } op_e;

  // command from controller to datapath
  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    func_e func;
    logic hit;
    logic match;
    logic full;
    logic idx_ok;
    logic bs_done;
    logic lin_done;
    logic ins_done;
    logic del_done;
  } dp_sts_t;
endpackage

// ----- sv/sorted_key_value_table.sv -----
// sorted key-value table: 256 entries in single-port rams, one transaction at a time
// a miss goes straight to the result, a read or cache hit first fetches the entry, a lookup may search
// insert searches, then shifts entries up to open a slot; delete shifts entries down; scan compares each entry
// a new transaction is accepted in the strobe cycle, not while the previous one is still busy
// reset clears fill count, cache and config (ordered_mode=1, scan_unordered=0)
// results appear for one cycle with result_valid_o; the receiver cannot stall
module sorted_key_value_table import skvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       result_valid_o,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [31:0] cfg_data_i
);
`include "assert_macros.svh"
  logic ordered_q, scan_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ordered_q <= 1'b1;
      scan_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORDERED: ordered_q <= cfg_data_i[0];
        CFG_SCAN: scan_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  skvt_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .ordered_i(ordered_q),
    .scan_i(scan_q), .sts_i(sts), .cmd_o(cmd), .busy_o(busy),
    .strobe_o(result_valid_o));

  skvt_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_i), .ordered_i(ordered_q),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp_o));

  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, rsp_o.entry_count <= CntW'(TableDepth), "count overflow")
  `ASSERT_NEXT(a_busy_on_start, clk_i, rst_ni, start && !busy, busy, "busy not raised")
endmodule

// ----- sv/skvt_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module skvt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/skvt_datapath.sv -----
// datapath: key/value rams, search bounds, cache, fill count, result register
// depends on skvt_pkg and skvt_ram
module skvt_datapath import skvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  logic    ordered_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);
  req_t req_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [31:0] ckey_q;
  logic [AddrW-1:0] cloc_q;
  logic cvalid_q;
  logic signed [CntW:0] lo_q, hi_q, mid, mid_p1, mid_m1;
  logic [CntW-1:0] ptr_q, ptr_inc, ptr_dec, loc_q;
  logic match_q, hit_q;
  logic [31:0] okey_q, oval_q;
  logic [AddrW-1:0] addr;
  logic we;
  logic [31:0] kw, vw, kr, vr;
  logic cache_ok, idx_ok, full, key_eq, key_lt;
  logic cinv, cload;
  rsp_t rsp_q, rsp_d;

  skvt_ram #(.Width(32), .Depth(TableDepth)) u_key (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(kw), .rdata_o(kr));
  skvt_ram #(.Width(32), .Depth(TableDepth)) u_val (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(vw), .rdata_o(vr));

  assign mid = lo_q + ((hi_q - lo_q) >>> 1);
  assign mid_p1 = mid + (CntW+1)'(1);
  assign mid_m1 = mid - (CntW+1)'(1);
  assign ptr_inc = ptr_q + 1'b1;
  assign ptr_dec = ptr_q - 1'b1;

  assign cache_ok = cvalid_q && (ckey_q == req_i.key) && ({1'b0, cloc_q} < fill_q);
  assign idx_ok = {1'b0, req_q.index} < fill_q;
  assign full = fill_q >= CntW'(TableDepth);
  assign key_eq = kr == req_q.key;
  assign key_lt = $signed(kr) < $signed(req_q.key);

  assign sts_o.func = func_e'(req_q.func);
  assign sts_o.hit = hit_q;
  assign sts_o.match = match_q;
  assign sts_o.full = full;
  assign sts_o.idx_ok = idx_ok;
  assign sts_o.bs_done = match_q || (lo_q > hi_q);
  assign sts_o.lin_done = match_q || (ptr_q >= fill_q);
  assign sts_o.ins_done = ptr_q == loc_q;
  assign sts_o.del_done = ptr_inc >= fill_q;

  assign rsp_o = rsp_q;

  // ram port, driven per op
  always_comb begin
    we = 1'b0;
    kw = req_q.key;
    vw = req_q.value;
    addr = ptr_q[AddrW-1:0];
    case (cmd_i.op)
      OP_RD_MID: addr = mid[AddrW-1:0];
      OP_RD_PREV: addr = ptr_dec[AddrW-1:0];
      OP_RD_NEXT: addr = ptr_inc[AddrW-1:0];
      OP_RD_LOC: addr = loc_q[AddrW-1:0];
      OP_WRITE: begin
        we = 1'b1;
        addr = loc_q[AddrW-1:0];
      end
      OP_WR_UP, OP_WR_DN: begin
        we = 1'b1;
        kw = kr;
        vw = vr;
      end
      default: ;
    endcase
  end

  // result, next fill count and cache action
  always_comb begin
    rsp_d = '0;
    fill_d = fill_q;
    cinv = 1'b0;
    cload = 1'b0;
    case (func_e'(req_q.func))
      FUNC_SET: begin
        rsp_d.out_key = req_q.key;
        rsp_d.out_value = req_q.value;
        rsp_d.cache_hit = hit_q;
        if (ordered_i && match_q) begin
          rsp_d.found = 1'b1;
          rsp_d.position = loc_q[AddrW-1:0];
        end else if (full) begin
          rsp_d.table_full = 1'b1;
        end else begin
          rsp_d.position = loc_q[AddrW-1:0];
          fill_d = fill_q + 1'b1;
          cinv = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        rsp_d.cache_hit = hit_q;
        if (!hit_q) begin
          cinv = !match_q;
          cload = match_q;
        end
        if (match_q) begin
          rsp_d.found = 1'b1;
          rsp_d.position = loc_q[AddrW-1:0];
          rsp_d.out_key = okey_q;
          rsp_d.out_value = oval_q;
        end
      end
      default: begin
        if (idx_ok) begin
          rsp_d.found = 1'b1;
          rsp_d.position = req_q.index;
          rsp_d.out_key = okey_q;
          rsp_d.out_value = oval_q;
          if (req_q.func == FUNC_DELETE) begin
            fill_d = fill_q - 1'b1;
            cinv = 1'b1;
          end
        end
      end
    endcase
    rsp_d.entry_count = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      fill_q <= '0;
      ckey_q <= '0;
      cloc_q <= '0;
      cvalid_q <= 1'b0;
      rsp_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      ptr_q <= '0;
      loc_q <= '0;
      match_q <= 1'b0;
      hit_q <= 1'b0;
      okey_q <= '0;
      oval_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          req_q <= req_i;
          lo_q <= '0;
          hi_q <= $signed({1'b0, fill_q}) - (CntW+1)'(1);
          ptr_q <= '0;
          if ((req_i.func inside {FUNC_SET, FUNC_LOOKUP}) && cache_ok) begin
            hit_q <= 1'b1;
            match_q <= 1'b1;
            loc_q <= {1'b0, cloc_q};
          end else begin
            hit_q <= 1'b0;
            match_q <= 1'b0;
            loc_q <= (req_i.func inside {FUNC_READ, FUNC_DELETE}) ?
                     {1'b0, req_i.index} : '0;
          end
        end
        OP_BS_CMP: begin
          // loc tracks the low bound, which is the insert point on a miss
          if (key_eq) begin
            match_q <= 1'b1;
            loc_q <= mid[CntW-1:0];
            okey_q <= kr;
            oval_q <= vr;
          end else if (key_lt) begin
            lo_q <= mid_p1;
            loc_q <= mid_p1[CntW-1:0];
          end else begin
            hi_q <= mid_m1;
          end
        end
        OP_LIN_CMP: begin
          if (key_eq) begin
            match_q <= 1'b1;
            loc_q <= ptr_q;
            okey_q <= kr;
            oval_q <= vr;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        OP_INS_PREP: begin
          if (!ordered_i) loc_q <= fill_q;
          ptr_q <= fill_q;
        end
        OP_WR_UP: ptr_q <= ptr_dec;
        OP_CAPTURE: begin
          okey_q <= kr;
          oval_q <= vr;
          ptr_q <= loc_q;
        end
        OP_WR_DN: ptr_q <= ptr_inc;
        OP_RESULT: begin
          rsp_q <= rsp_d;
          fill_q <= fill_d;
          if (cload) begin
            cvalid_q <= 1'b1;
            ckey_q <= req_q.key;
            cloc_q <= loc_q[AddrW-1:0];
          end else if (cinv) begin
            cvalid_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/skvt_ctrl.sv -----
// controller state machine sequencing search, shift and result
// depends on skvt_pkg
module skvt_ctrl import skvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    ordered_i,
  input  logic    scan_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    strobe_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_BS, S_BS_CMP, S_LIN, S_LIN_CMP, S_SET_DEC, S_SH_CHK,
    S_SH_WR, S_WRITE, S_FETCH, S_FETCH_CAP, S_DEL_CHK, S_DEL_WR, S_RESULT
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o.op = OP_IDLE;
    case (state_q)
      S_IDLE: cmd_o.op = start_i ? OP_LOAD : OP_IDLE;
      S_BS: cmd_o.op = OP_RD_MID;
      S_BS_CMP: cmd_o.op = OP_BS_CMP;
      S_LIN: cmd_o.op = OP_RD_PTR;
      S_LIN_CMP: cmd_o.op = OP_LIN_CMP;
      S_SET_DEC: cmd_o.op = OP_INS_PREP;
      S_SH_CHK: cmd_o.op = OP_RD_PREV;
      S_SH_WR: cmd_o.op = OP_WR_UP;
      S_WRITE: cmd_o.op = OP_WRITE;
      S_FETCH: cmd_o.op = OP_RD_LOC;
      S_FETCH_CAP: cmd_o.op = OP_CAPTURE;
      S_DEL_CHK: cmd_o.op = OP_RD_NEXT;
      S_DEL_WR: cmd_o.op = OP_WR_DN;
      S_RESULT: cmd_o.op = OP_RESULT;
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_o <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) begin
          busy_o <= 1'b1;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          case (sts_i.func)
            FUNC_SET: state_q <= (sts_i.hit || !ordered_i) ? S_SET_DEC : S_BS;
            FUNC_LOOKUP: begin
              if (sts_i.hit) state_q <= S_FETCH;
              else if (ordered_i) state_q <= S_BS;
              else if (scan_i) state_q <= S_LIN;
              else state_q <= S_RESULT;
            end
            default: state_q <= sts_i.idx_ok ? S_FETCH : S_RESULT;
          endcase
        end
        S_BS: begin
          if (!sts_i.bs_done) state_q <= S_BS_CMP;
          else if (sts_i.func == FUNC_SET) state_q <= S_SET_DEC;
          else state_q <= S_RESULT;
        end
        S_BS_CMP: state_q <= S_BS;
        S_LIN: state_q <= sts_i.lin_done ? S_RESULT : S_LIN_CMP;
        S_LIN_CMP: state_q <= S_LIN;
        S_SET_DEC: begin
          // replace, drop on a full table, or open a slot by shifting up
          if (ordered_i && sts_i.match) state_q <= S_WRITE;
          else if (sts_i.full) state_q <= S_RESULT;
          else state_q <= S_SH_CHK;
        end
        S_SH_CHK: state_q <= sts_i.ins_done ? S_WRITE : S_SH_WR;
        S_SH_WR: state_q <= S_SH_CHK;
        S_WRITE: state_q <= S_RESULT;
        S_FETCH: state_q <= S_FETCH_CAP;
        S_FETCH_CAP: state_q <= (sts_i.func == FUNC_DELETE) ? S_DEL_CHK : S_RESULT;
        S_DEL_CHK: state_q <= sts_i.del_done ? S_RESULT : S_DEL_WR;
        S_DEL_WR: state_q <= S_DEL_CHK;
        S_RESULT: begin
          strobe_o <= 1'b1;
          busy_o <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
